>>> rtl/rlwe_pkg.sv
// Package for the run-length word encoder: widths, run limits and the
// transaction payload types shared by the encoder and its checker.
// Depends on nothing.
package rlwe_pkg;

  localparam int unsigned WORD_W    = 8;
  localparam int unsigned LANES     = 8;
  localparam int unsigned LANE_W    = $clog2(LANES);
  localparam int unsigned FILL_W    = LANE_W + 1;
  localparam int unsigned MAX_RUN   = 128;
  localparam int unsigned CNT_W     = $clog2(MAX_RUN + 2);
  localparam int unsigned MEM_DEPTH = 256;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [FILL_W-1:0] fill_t;

  localparam cnt_t  CNT_MAX    = cnt_t'(MAX_RUN);
  localparam cnt_t  CNT_MAX_P1 = cnt_t'(MAX_RUN + 1);
  localparam fill_t FILL_FULL  = fill_t'(LANES);

  typedef struct packed {
    logic [7:0] data_word;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_word0;
    logic [7:0] out_word1;
    logic [7:0] out_word2;
    logic [7:0] out_word3;
    logic [7:0] out_word4;
    logic [7:0] out_word5;
    logic [7:0] out_word6;
    logic [7:0] out_word7;
    logic [3:0] valid_words;
    logic       frame_end;
  } out_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_REP_HDR  = 7'b0000010,
    ST_REP_VAL  = 7'b0000100,
    ST_LIT_HDR  = 7'b0001000,
    ST_LIT_DATA = 7'b0010000,
    ST_END      = 7'b0100000,
    ST_FINAL    = 7'b1000000
  } state_e;

endpackage

>>> rtl/rlwe_ram.sv
// Generic single-clock RAM: one write port and one read port with a
// registered, enabled read. Depends on nothing.
module rlwe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/run_length_word_encoder.sv
// Top level of the run-length word encoder: run detection, literal buffer
// sequencing and eight-lane output packing. Depends on rlwe_pkg and rlwe_ram.
//
//   channel | direction | payload          | handshake
//   in      | input     | rlwe_pkg::in_t   | in_valid_i / in_ready_o
//   out     | output    | rlwe_pkg::out_t  | out_valid_o / out_ready_i
//
// A word that closes no run leaves the input ready, and the next word may follow at once.
// A word that closes a run holds the input until its header and value or literal words are out,
// with one literal RAM read and one lane write a cycle while the pack can take a word.
// The last word of a frame adds the frame-end flush (ST_END) and the closing of the pack (ST_FINAL).
// Reset clears the run state; the literal RAM needs no clearing, as only written entries are read.
// While a result waits on out_ready_i, packing stops once all eight lanes are filled.
module run_length_word_encoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rlwe_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rlwe_pkg::out_t out_o
);

  rlwe_pkg::state_e state_q, state_d;

  logic             rep_q, rep_d;
  rlwe_pkg::cnt_t   cnt_q, cnt_d;
  rlwe_pkg::word_t  rval_q, rval_d;
  rlwe_pkg::word_t  last1_q, last1_d;
  rlwe_pkg::word_t  last2_q, last2_d;
  rlwe_pkg::addr_t  base_q, base_d;
  rlwe_pkg::addr_t  rd_ptr_q, rd_ptr_d;
  rlwe_pkg::cnt_t   em_cnt_q, em_cnt_d;
  rlwe_pkg::word_t  em_val_q, em_val_d;
  rlwe_pkg::cnt_t   lit_left_q, lit_left_d;
  logic             extra_q, extra_d;
  logic             last_pend_q, last_pend_d;
  logic             fin_q, fin_d;
  logic             pack_final_q, pack_final_d;

  rlwe_pkg::word_t  pack_q [rlwe_pkg::LANES];
  rlwe_pkg::fill_t  fill_q, fill_d;
  rlwe_pkg::out_t   out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             in_acc;
  logic             put_req;
  logic             put_en;
  logic             can_put;
  logic             take;
  logic             final_now;
  rlwe_pkg::word_t  put_word;
  rlwe_pkg::state_e after_job;
  rlwe_pkg::word_t  w;
  rlwe_pkg::word_t  lanes_m [rlwe_pkg::LANES];
  logic [rlwe_pkg::LANE_W-1:0] lane;

  logic             mem_we;
  rlwe_pkg::addr_t  mem_waddr;
  logic             mem_re;
  rlwe_pkg::word_t  mem_rdata;

  rlwe_ram #(
    .Width(rlwe_pkg::WORD_W),
    .Depth(rlwe_pkg::MEM_DEPTH)
  ) u_lit_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(w),
    .re_i   (mem_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(mem_rdata)
  );

  assign w           = in_i.data_word;
  assign in_ready_o  = (state_q == rlwe_pkg::ST_IDLE) && !pack_final_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The pack leaves when full, or holding the tail of a frame.
  assign final_now = pack_final_q || (state_q == rlwe_pkg::ST_FINAL);
  assign take      = (!out_valid_q || out_ready_i) && (fill_q != '0) &&
                     ((fill_q == rlwe_pkg::FILL_FULL) || final_now);
  assign can_put   = (fill_q != rlwe_pkg::FILL_FULL) || take;
  assign put_en    = put_req && can_put;
  assign lane      = take ? '0 : fill_q[rlwe_pkg::LANE_W-1:0];

  always_comb begin
    after_job = rlwe_pkg::ST_IDLE;
    if (last_pend_q) begin
      after_job = rlwe_pkg::ST_END;
    end else if (fin_q) begin
      after_job = rlwe_pkg::ST_FINAL;
    end
  end

  always_comb begin
    state_d     = state_q;
    rep_d       = rep_q;
    cnt_d       = cnt_q;
    rval_d      = rval_q;
    last1_d     = last1_q;
    last2_d     = last2_q;
    base_d      = base_q;
    rd_ptr_d    = rd_ptr_q;
    em_cnt_d    = em_cnt_q;
    em_val_d    = em_val_q;
    lit_left_d  = lit_left_q;
    extra_d     = extra_q;
    last_pend_d = last_pend_q;
    fin_d       = fin_q;
    put_req     = 1'b0;
    put_word    = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = base_q + (rep_q ? '0 : rlwe_pkg::addr_t'(cnt_q));

    case (state_q)
      rlwe_pkg::ST_IDLE: begin
        if (in_acc) begin
          mem_we      = 1'b1;
          last_pend_d = in_i.frame_last;
          state_d     = in_i.frame_last ? rlwe_pkg::ST_END : rlwe_pkg::ST_IDLE;
          if (rep_q) begin
            if (w == rval_q) begin
              if (cnt_q == rlwe_pkg::CNT_MAX - 1'b1) begin
                em_cnt_d = rlwe_pkg::CNT_MAX;
                em_val_d = rval_q;
                rep_d    = 1'b0;
                cnt_d    = '0;
                state_d  = rlwe_pkg::ST_REP_HDR;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end else begin
              em_cnt_d = cnt_q;
              em_val_d = rval_q;
              rep_d    = 1'b0;
              cnt_d    = rlwe_pkg::cnt_t'(1);
              last1_d  = w;
              state_d  = rlwe_pkg::ST_REP_HDR;
            end
          end else if (cnt_q == '0) begin
            cnt_d   = rlwe_pkg::cnt_t'(1);
            last1_d = w;
          end else if (cnt_q == rlwe_pkg::cnt_t'(1)) begin
            if (w == last1_q) begin
              rep_d  = 1'b1;
              rval_d = w;
              cnt_d  = rlwe_pkg::cnt_t'(2);
            end else begin
              cnt_d   = rlwe_pkg::cnt_t'(2);
              last2_d = last1_q;
              last1_d = w;
            end
          end else if (cnt_q >= rlwe_pkg::cnt_t'(3) && last2_q == last1_q && last1_q == w) begin
            // Three equal words close the literal before them.
            em_cnt_d   = cnt_q - rlwe_pkg::cnt_t'(2);
            lit_left_d = cnt_q - rlwe_pkg::cnt_t'(2);
            rd_ptr_d   = base_q;
            rep_d      = 1'b1;
            rval_d     = w;
            cnt_d      = rlwe_pkg::cnt_t'(3);
            state_d    = rlwe_pkg::ST_LIT_HDR;
          end else if (cnt_q == rlwe_pkg::CNT_MAX_P1) begin
            // Literal cap: the full run goes out, the last two words stay.
            em_cnt_d   = rlwe_pkg::CNT_MAX;
            lit_left_d = rlwe_pkg::CNT_MAX;
            rd_ptr_d   = base_q;
            base_d     = base_q + rlwe_pkg::addr_t'(rlwe_pkg::MAX_RUN);
            cnt_d      = rlwe_pkg::cnt_t'(2);
            state_d    = rlwe_pkg::ST_LIT_HDR;
            if (last1_q == w) begin
              rep_d  = 1'b1;
              rval_d = w;
            end else begin
              last2_d = last1_q;
              last1_d = w;
            end
          end else begin
            cnt_d   = cnt_q + 1'b1;
            last2_d = last1_q;
            last1_d = w;
          end
        end
      end
      rlwe_pkg::ST_REP_HDR: begin
        put_req  = 1'b1;
        put_word = {1'b1, em_cnt_q[rlwe_pkg::WORD_W-2:0]};
        if (can_put) begin
          state_d = rlwe_pkg::ST_REP_VAL;
        end
      end
      rlwe_pkg::ST_REP_VAL: begin
        put_req  = 1'b1;
        put_word = em_val_q;
        if (can_put) begin
          state_d = after_job;
        end
      end
      rlwe_pkg::ST_LIT_HDR: begin
        put_req  = 1'b1;
        put_word = {1'b0, em_cnt_q[rlwe_pkg::WORD_W-2:0]};
        if (can_put) begin
          mem_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
          state_d  = rlwe_pkg::ST_LIT_DATA;
        end
      end
      rlwe_pkg::ST_LIT_DATA: begin
        put_req  = 1'b1;
        put_word = mem_rdata;
        if (can_put) begin
          if (lit_left_q == rlwe_pkg::cnt_t'(1)) begin
            if (extra_q) begin
              // The single word left over after a capped literal at frame end.
              em_cnt_d   = rlwe_pkg::cnt_t'(1);
              lit_left_d = rlwe_pkg::cnt_t'(1);
              extra_d    = 1'b0;
              state_d    = rlwe_pkg::ST_LIT_HDR;
            end else begin
              state_d = after_job;
            end
          end else begin
            mem_re     = 1'b1;
            rd_ptr_d   = rd_ptr_q + 1'b1;
            lit_left_d = lit_left_q - 1'b1;
          end
        end
      end
      rlwe_pkg::ST_END: begin
        last_pend_d = 1'b0;
        fin_d       = 1'b1;
        rep_d       = 1'b0;
        cnt_d       = '0;
        if (rep_q) begin
          em_cnt_d = cnt_q;
          em_val_d = rval_q;
          state_d  = rlwe_pkg::ST_REP_HDR;
        end else if (cnt_q != '0) begin
          em_cnt_d   = (cnt_q > rlwe_pkg::CNT_MAX) ? rlwe_pkg::CNT_MAX : cnt_q;
          lit_left_d = (cnt_q > rlwe_pkg::CNT_MAX) ? rlwe_pkg::CNT_MAX : cnt_q;
          extra_d    = cnt_q > rlwe_pkg::CNT_MAX;
          rd_ptr_d   = base_q;
          state_d    = rlwe_pkg::ST_LIT_HDR;
        end else begin
          state_d = rlwe_pkg::ST_FINAL;
        end
      end
      rlwe_pkg::ST_FINAL: begin
        fin_d   = 1'b0;
        state_d = rlwe_pkg::ST_IDLE;
      end
      default: begin
        state_d = rlwe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < rlwe_pkg::LANES; i++) begin
      lanes_m[i] = (rlwe_pkg::fill_t'(i) < fill_q) ? pack_q[i] : '0;
    end
    out_d = out_q;
    if (take) begin
      out_d.out_word0   = lanes_m[0];
      out_d.out_word1   = lanes_m[1];
      out_d.out_word2   = lanes_m[2];
      out_d.out_word3   = lanes_m[3];
      out_d.out_word4   = lanes_m[4];
      out_d.out_word5   = lanes_m[5];
      out_d.out_word6   = lanes_m[6];
      out_d.out_word7   = lanes_m[7];
      out_d.valid_words = 4'(fill_q);
      out_d.frame_end   = final_now;
    end
    out_valid_d  = take || (out_valid_q && !out_ready_i);
    fill_d       = (take ? '0 : fill_q) + rlwe_pkg::fill_t'(put_en);
    pack_final_d = final_now && !take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rlwe_pkg::ST_IDLE;
      rep_q        <= 1'b0;
      cnt_q        <= '0;
      base_q       <= '0;
      rd_ptr_q     <= '0;
      em_cnt_q     <= '0;
      lit_left_q   <= '0;
      extra_q      <= 1'b0;
      last_pend_q  <= 1'b0;
      fin_q        <= 1'b0;
      pack_final_q <= 1'b0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rep_q        <= rep_d;
      cnt_q        <= cnt_d;
      base_q       <= base_d;
      rd_ptr_q     <= rd_ptr_d;
      em_cnt_q     <= em_cnt_d;
      lit_left_q   <= lit_left_d;
      extra_q      <= extra_d;
      last_pend_q  <= last_pend_d;
      fin_q        <= fin_d;
      pack_final_q <= pack_final_d;
      fill_q       <= fill_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rval_q   <= rval_d;
    last1_q  <= last1_d;
    last2_q  <= last2_d;
    em_val_q <= em_val_d;
    out_q    <= out_d;
    if (put_en) begin
      pack_q[lane] <= put_word;
    end
  end

endmodule

>>> rtl/rlwe_checker.sv
// Port-level checker for the run-length word encoder, bound to the top level.
// Depends on rlwe_pkg and run_length_word_encoder.
module rlwe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input rlwe_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rlwe_pkg::out_t out_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_words_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.valid_words != 4'd0 && out_o.valid_words <= 4'd8)
    else $error("valid_words out of range");

  // Only the closing result of a frame may be partly filled.
  a_partial_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.frame_end |-> out_o.valid_words == 4'd8)
    else $error("partial result before frame end");

  a_unused_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.valid_words < 4'd8 |-> out_o.out_word7 == 8'd0)
    else $error("unused lane not cleared");

  // The input is never ready in the cycle after the last word of a frame is taken.
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.frame_last |=> !in_ready_o)
    else $error("input taken during frame-end flush");

endmodule

bind run_length_word_encoder rlwe_checker u_rlwe_checker (.*);
